FILE: hdl/rmsn_pkg.sv
// Shared types, constants and helpers for the running mean/deviation normalizer.
// No dependencies; imported by every module of the block.
package rmsn_pkg;

  localparam int unsigned DIM_COUNT_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned STEPS_W    = 7;
  localparam int unsigned MEAN_STEPS = 33;
  localparam int unsigned RAD_STEPS  = 62;
  localparam int unsigned SQRT_STEPS = 31;

  localparam logic [30:0] SPREAD_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_NORM   = 2'd0,
    OP_DENORM = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DISP,
    ST_NORM_DIV,
    ST_DEN_END,
    ST_UPD_DIV,
    ST_UPD_DD,
    ST_UPD_PLO,
    ST_UPD_PHI,
    ST_UPD_MM,
    ST_UPD_CHK,
    ST_UPD_RDIV,
    ST_UPD_ROOT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [31:0]        count;
    logic [30:0]        spread;
    logic signed [31:0] mean;
  } stats_t;

  // divider start request: left-aligned dividend, starting remainder, step count
  typedef struct packed {
    logic               start;
    logic [31:0]        rem;
    logic [63:0]        num;
    logic [31:0]        den;
    logic [STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [61:0] rad;
  } sqrt_req_t;

  // {saturated, value} of a 64-bit signed value clamped to 32 bits
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: hdl/rmsn_stats.sv
// Per-dimension statistics memory (mean, deviation, count) with valid bits.
// Entries never written read as the reset values. Depends on rmsn_pkg.
module rmsn_stats #(
  parameter int unsigned DIM_COUNT = rmsn_pkg::DIM_COUNT_DEF,
  parameter int unsigned FRAC_BITS = rmsn_pkg::FRAC_BITS_DEF,
  localparam int unsigned IW = (DIM_COUNT > 1) ? $clog2(DIM_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IW-1:0]    rd_idx_i,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  rmsn_pkg::stats_t wr_data_i,
  output rmsn_pkg::stats_t rd_data_o
);
  import rmsn_pkg::*;

  stats_t               mem_q [DIM_COUNT];
  logic [DIM_COUNT-1:0] vld_q;
  stats_t               rd_q;
  logic                 rd_vld_q;
  stats_t               rst_val;

  assign rst_val.count  = '0;
  assign rst_val.spread = 31'(1) << FRAC_BITS;
  assign rst_val.mean   = '0;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : rst_val;

endmodule

FILE: hdl/rmsn_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
// Dividend is left-aligned in 64 bits; quotient appears in the low bits. Depends on rmsn_pkg.
module rmsn_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmsn_pkg::div_req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [63:0]        quo_o
);
  import rmsn_pkg::*;

  logic               busy_q;
  logic [STEPS_W-1:0] cnt_q;
  logic [31:0]        rem_q;
  logic [63:0]        num_q;
  logic [31:0]        den_q;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               ge;

  assign trial = {rem_q, num_q[63]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      num_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      num_q <= {num_q[62:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = num_q;

endmodule

FILE: hdl/rmsn_sqrt.sv
// Iterative digit-by-digit integer square root of a 62-bit radicand, one root bit a cycle.
// Depends on rmsn_pkg.
module rmsn_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmsn_pkg::sqrt_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [30:0]         root_o
);
  import rmsn_pkg::*;

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [61:0] rad_q;
  logic [31:0] rem_q;
  logic [30:0] root_q;
  logic [33:0] cur;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  assign cur   = {rem_q, rad_q[61:60]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(SQRT_STEPS);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // remainder stays at most 2*root, so 32 bits hold it
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rad_q  <= {rad_q[59:0], 2'b00};
      rem_q  <= ge ? diff[31:0] : cur[31:0];
      root_q <= {root_q[29:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

endmodule

FILE: hdl/running_mean_std_normalizer_core.sv
// Update runs a 33-step mean division, then a 62-step radicand division and a 31-step root;
// the radicand division and root are skipped for the first sample and when the root saturates.
// One item at a time: the next item is taken the cycle after the result is loaded, so output
// stalls delay it; item spacing is set by the shared divider and root unit.
// Reset (async, active low) returns every dimension to mean 0, deviation 1.0, count 0 via valid bits.
module running_mean_std_normalizer_core #(
  parameter int unsigned DIM_COUNT = rmsn_pkg::DIM_COUNT_DEF,
  parameter int unsigned FRAC_BITS = rmsn_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // dim_index[3:0], sample[35:4], spread_in[66:36]
  input  logic [1:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // value_out, mean_out, spread_out, count_out
  output logic [0:0]   m_axis_tuser    // fault
);
  import rmsn_pkg::*;

  localparam int unsigned IW = (DIM_COUNT > 1) ? $clog2(DIM_COUNT) : 1;
  localparam logic [STEPS_W-1:0] NORM_STEPS = STEPS_W'(33 + FRAC_BITS);

  state_e             state_q, state_d;
  op_e                op_q;
  logic [3:0]         dim_q;
  logic signed [31:0] x_q;
  logic [30:0]        spin_q;
  logic signed [31:0] mean_q, mean_d;
  logic [30:0]        dev_q, dev_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        n_q, n_d;
  logic signed [32:0] delta_q, delta_d;
  logic [32:0]        m2_q, m2_d;
  logic               neg_q, neg_d;
  logic [61:0]        dd_q, dd_d;
  logic [62:0]        pa_q, pa_d;
  logic [95:0]        sum_q, sum_d;
  logic [31:0]        value_q, value_d;
  logic               fault_q, fault_d;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;
  logic               m_valid_q;
  logic [126:0]       m_data_q;
  logic               m_fault_q;
  logic               out_load;

  logic               in_range;
  logic               accept;
  logic               mem_re, mem_we;
  stats_t             rd_data, wr_data;

  div_req_t           div_req;
  logic               div_busy, div_done;
  logic [63:0]        quo;
  sqrt_req_t          sqrt_req;
  logic               sqrt_busy, sqrt_done;
  logic [30:0]        root;

  logic signed [32:0] diff_x;
  logic [32:0]        diff_mag;
  logic [32:0]        m1;
  logic [31:0]        n_next;
  logic [31:0]        n_m1;
  logic signed [32:0] delta2;
  logic [63:0]        den_mag;
  logic [63:0]        den_sh;
  logic signed [63:0] den_res;
  logic signed [63:0] mean_sum;
  logic [32:0]        sat_r;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_range      = 32'(dim_q) < DIM_COUNT;

  assign diff_x   = 33'(x_q) - 33'(mean_q);
  assign diff_mag = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
  assign m1       = delta_q[32] ? 33'(-delta_q) : 33'(delta_q);
  assign n_next   = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
  assign n_m1     = n_q - 32'd1;
  assign delta2   = 33'(x_q) - 33'(mean_q);

  // denormalize: truncate the scaled product toward zero, then add the mean
  assign den_mag  = prod_q[67] ? 64'(-prod_q) : 64'(prod_q);
  assign den_sh   = den_mag >> FRAC_BITS;
  assign den_res  = (prod_q[67] ? -signed'(den_sh) : signed'(den_sh)) + 64'(mean_q);
  assign mean_sum = 64'(mean_q) + (delta_q[32] ? -signed'(64'(quo[32:0]))
                                               : signed'(64'(quo[32:0])));

  rmsn_stats #(
    .DIM_COUNT(DIM_COUNT),
    .FRAC_BITS(FRAC_BITS)
  ) u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (mem_re),
    .rd_idx_i (IW'(dim_q)),
    .wr_en_i  (mem_we),
    .wr_idx_i (IW'(dim_q)),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  rmsn_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .busy_o(div_busy),
    .done_o(div_done),
    .quo_o (quo)
  );

  rmsn_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sqrt_req),
    .busy_o(sqrt_busy),
    .done_o(sqrt_done),
    .root_o(root)
  );

  assign wr_data.count  = cnt_q;
  assign wr_data.spread = dev_q;
  assign wr_data.mean   = mean_q;

  always_comb begin
    state_d  = state_q;
    mean_d   = mean_q;
    dev_d    = dev_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    delta_d  = delta_q;
    m2_d     = m2_q;
    neg_d    = neg_q;
    dd_d     = dd_q;
    pa_d     = pa_q;
    sum_d    = sum_q;
    value_d  = value_q;
    fault_d  = fault_q;
    mul_a    = '0;
    mul_b    = '0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    sat_r    = '0;
    div_req  = '0;
    sqrt_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = in_range;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        value_d = '0;
        if (in_range) begin
          mean_d  = rd_data.mean;
          dev_d   = rd_data.spread;
          cnt_d   = rd_data.count;
          fault_d = 1'b0;
        end else begin
          mean_d  = '0;
          dev_d   = '0;
          cnt_d   = '0;
          fault_d = 1'b1;
        end
        state_d = ST_DISP;
      end
      ST_DISP: begin
        if (!in_range) begin
          state_d = ST_FIN;
        end else begin
          case (op_q)
            OP_NORM: begin
              if (dev_q == '0) begin
                fault_d = 1'b1;
                if (diff_x == '0) begin
                  value_d = '0;
                end else begin
                  value_d = diff_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                state_d = ST_FIN;
              end else begin
                div_req.start = 1'b1;
                div_req.num   = {diff_mag, 31'b0};
                div_req.den   = {1'b0, dev_q};
                div_req.steps = NORM_STEPS;
                state_d       = ST_NORM_DIV;
              end
            end
            OP_DENORM: begin
              mul_a   = 34'(x_q);
              mul_b   = 34'({1'b0, dev_q});
              state_d = ST_DEN_END;
            end
            OP_UPDATE: begin
              if (cnt_q == 32'hFFFF_FFFF) begin
                fault_d = 1'b1;
              end
              n_d           = n_next;
              delta_d       = diff_x;
              div_req.start = 1'b1;
              div_req.num   = {diff_mag, 31'b0};
              div_req.den   = n_next;
              div_req.steps = STEPS_W'(MEAN_STEPS);
              state_d       = ST_UPD_DIV;
            end
            OP_LOAD: begin
              mean_d  = x_q;
              dev_d   = spin_q;
              cnt_d   = '0;
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_NORM_DIV: begin
        if (div_done) begin
          if (diff_x[32]) begin
            if (quo > 64'h8000_0000) begin
              value_d = 32'h8000_0000;
              fault_d = 1'b1;
            end else begin
              value_d = 32'(-quo);
            end
          end else begin
            if (quo > 64'h7FFF_FFFF) begin
              value_d = 32'h7FFF_FFFF;
              fault_d = 1'b1;
            end else begin
              value_d = quo[31:0];
            end
          end
          state_d = ST_FIN;
        end
      end
      ST_DEN_END: begin
        sat_r   = sat32(den_res);
        value_d = sat_r[31:0];
        fault_d = fault_q | sat_r[32];
        state_d = ST_FIN;
      end
      ST_UPD_DIV: begin
        if (div_done) begin
          sat_r   = sat32(mean_sum);
          mean_d  = sat_r[31:0];
          fault_d = fault_q | sat_r[32];
          cnt_d   = n_q;
          mul_a   = 34'({1'b0, dev_q});
          mul_b   = 34'({1'b0, dev_q});
          state_d = (n_q > 32'd1) ? ST_UPD_DD : ST_FIN;
        end
      end
      ST_UPD_DD: begin
        // dev*dev is in prod_q; start its low half times n-1
        dd_d  = prod_q[61:0];
        m2_d  = delta2[32] ? 33'(-delta2) : 33'(delta2);
        neg_d = (delta_q[32] != delta2[32]) && (delta_q != '0) && (delta2 != '0);
        mul_a = 34'(prod_q[30:0]);
        mul_b = 34'(n_m1);
        state_d = ST_UPD_PLO;
      end
      ST_UPD_PLO: begin
        pa_d    = prod_q[62:0];
        mul_a   = 34'(dd_q[61:31]);
        mul_b   = 34'(n_m1);
        state_d = ST_UPD_PHI;
      end
      ST_UPD_PHI: begin
        sum_d   = (96'(prod_q[63:0]) << 31) + 96'(pa_q);
        mul_a   = 34'(m1);
        mul_b   = 34'(m2_q);
        state_d = ST_UPD_MM;
      end
      ST_UPD_MM: begin
        // opposite-sign cross term: radicand clamps to zero
        sum_d   = neg_q ? '0 : sum_q + 96'(prod_q[65:0]);
        state_d = ST_UPD_CHK;
      end
      ST_UPD_CHK: begin
        // quotient >= 2^62 means the root would not fit in 31 bits
        if (sum_q[95:62] >= 34'(n_q)) begin
          dev_d   = SPREAD_MAX;
          fault_d = 1'b1;
          state_d = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          div_req.rem   = sum_q[93:62];
          div_req.num   = {sum_q[61:0], 2'b00};
          div_req.den   = n_q;
          div_req.steps = STEPS_W'(RAD_STEPS);
          state_d       = ST_UPD_RDIV;
        end
      end
      ST_UPD_RDIV: begin
        if (div_done) begin
          sqrt_req.start = 1'b1;
          sqrt_req.rad   = quo[61:0];
          state_d        = ST_UPD_ROOT;
        end
      end
      ST_UPD_ROOT: begin
        if (sqrt_done) begin
          dev_d   = root;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          mem_we   = in_range && (op_q == OP_UPDATE || op_q == OP_LOAD);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_axis_tuser);
      dim_q  <= s_axis_tdata[3:0];
      x_q    <= s_axis_tdata[35:4];
      spin_q <= s_axis_tdata[66:36];
    end
    mean_q  <= mean_d;
    dev_q   <= dev_d;
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    delta_q <= delta_d;
    m2_q    <= m2_d;
    neg_q   <= neg_d;
    dd_q    <= dd_d;
    pa_q    <= pa_d;
    sum_q   <= sum_d;
    value_q <= value_d;
    fault_q <= fault_d;
    prod_q  <= mul_a * mul_b;
    if (out_load) begin
      m_data_q  <= {cnt_q, dev_q, mean_q, value_q};
      m_fault_q <= fault_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};
  assign m_axis_tuser  = m_fault_q;

`ifndef SYNTHESIS
  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!div_busy && !sqrt_busy))
    else $error("arithmetic unit busy while idle");

  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ))
    else $error("accepted item did not start a read");

  a_wr_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (in_range && (op_q == OP_UPDATE || op_q == OP_LOAD)))
    else $error("statistics written for a non-writing item");

  a_sqrt_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_req.start |-> $past(state_q == ST_UPD_RDIV || state_q == ST_UPD_CHK))
    else $error("root started without a radicand division");
`endif

endmodule
